[rtl/core/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants for the sighting table
// Field widths, kind and status codes, the search packet that walks the
// cell chain, the insert bus and the sighting classifier.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Table size default and widest slot index (table holds up to 256 slots)
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int IDX_W           = 8;

    localparam int ADDR_W  = 48;
    localparam int RSSI_W  = 8;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int LEN_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd5;

    // Device kinds
    localparam logic [KIND_W-1:0] KIND_GENERIC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MFG_A   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MFG_B   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SERVICE = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_UPDATED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CLEARED  = 2'd3;

    // Manufacturer data signatures
    localparam logic [BYTE_W-1:0] MFG_A_B0 = 8'h4C;
    localparam logic [BYTE_W-1:0] MFG_A_B1 = 8'h00;
    localparam logic [BYTE_W-1:0] MFG_A_B2 = 8'h12;
    localparam logic [BYTE_W-1:0] MFG_B_B0 = 8'h75;
    localparam logic [BYTE_W-1:0] MFG_B_B1 = 8'h00;
    localparam logic [LEN_W-1:0]  MFG_A_LEN = 5'd3;
    localparam logic [LEN_W-1:0]  MFG_B_LEN = 5'd2;

    // Search packet, one cell per cycle
    typedef struct packed {
        logic               active;
        logic [ADDR_W-1:0]  addr;
        logic [KIND_W-1:0]  kind;
        logic [RSSI_W-1:0]  strength;
        logic [TIME_W-1:0]  time_ms;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic [COUNT_W-1:0] hit_count;
        logic               hit_tracker;
        logic [KIND_W-1:0]  hit_kind;
        logic               free_seen;
        logic [IDX_W-1:0]   free_idx;
    } pkt_t;

    // Insert write, broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] strength;
        logic [TIME_W-1:0] time_ms;
        logic              tracker;
        logic [KIND_W-1:0] kind;
    } ins_t;

    // First matching signature wins
    function automatic logic [KIND_W-1:0] classify(
        input logic [LEN_W-1:0]  len,
        input logic [BYTE_W-1:0] b0,
        input logic [BYTE_W-1:0] b1,
        input logic [BYTE_W-1:0] b2,
        input logic              svc
    );
        logic [KIND_W-1:0] k;
        if (len >= MFG_A_LEN && b0 == MFG_A_B0 && b1 == MFG_A_B1 && b2 == MFG_A_B2)
            k = KIND_MFG_A;
        else if (len >= MFG_B_LEN && b0 == MFG_B_B0 && b1 == MFG_B_B1)
            k = KIND_MFG_B;
        else if (svc)
            k = KIND_SERVICE;
        else
            k = KIND_GENERIC;
        return k;
    endfunction

endpackage

[rtl/core/bts_cell.sv]
// ----------------------------------------------------------------------------
// bts_cell: one slot of the sighting table
// Holds one entry, compares it against the passing search packet, updates
// itself on a hit, notes the first free slot and forwards the packet.
// ----------------------------------------------------------------------------
module bts_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bts_pkg::pkt_t pkt_i,
    input  bts_pkg::ins_t ins,
    input  logic          clr,
    output bts_pkg::pkt_t pkt_o
);
    import bts_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic               valid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [RSSI_W-1:0]  strength_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  first_seen_reg;
    logic [TIME_W-1:0]  last_seen_reg;
    logic               tracker_reg;
    logic [KIND_W-1:0]  kind_reg;
    pkt_t               pkt_reg;
    pkt_t               pkt_next;

    logic               hit_here;
    logic               ins_here;
    logic [COUNT_W-1:0] count_upd;
    logic               tracker_upd;
    logic [KIND_W-1:0]  kind_upd;

    // Match and entry update values
    always_comb
    begin
        hit_here    = pkt_i.active && valid_reg && (addr_reg == pkt_i.addr);
        ins_here    = ins.en && (ins.idx == MY_IDX);
        count_upd   = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
        tracker_upd = tracker_reg || (pkt_i.kind != KIND_GENERIC);
        kind_upd    = (pkt_i.kind != KIND_GENERIC) ? pkt_i.kind : kind_reg;
    end

    // Packet forwarding: hit result and first free slot
    always_comb
    begin
        pkt_next = pkt_i;
        if (hit_here)
        begin
            pkt_next.hit         = 1'b1;
            pkt_next.hit_idx     = MY_IDX;
            pkt_next.hit_count   = count_upd;
            pkt_next.hit_tracker = tracker_upd;
            pkt_next.hit_kind    = kind_upd;
        end
        if (pkt_i.active && !valid_reg && !pkt_i.free_seen)
        begin
            pkt_next.free_seen = 1'b1;
            pkt_next.free_idx  = MY_IDX;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pkt_reg   <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (clr)
                valid_reg <= 1'b0;
            else if (ins_here)
                valid_reg <= 1'b1;
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (ins_here)
        begin
            addr_reg       <= ins.addr;
            strength_reg   <= ins.strength;
            count_reg      <= COUNT_W'(1);
            first_seen_reg <= ins.time_ms;
            last_seen_reg  <= ins.time_ms;
            tracker_reg    <= ins.tracker;
            kind_reg       <= ins.kind;
        end
        else if (hit_here)
        begin
            strength_reg  <= pkt_i.strength;
            count_reg     <= count_upd;
            last_seen_reg <= pkt_i.time_ms;
            tracker_reg   <= tracker_upd;
            kind_reg      <= kind_upd;
        end
    end

    assign pkt_o = pkt_reg;

    // An address lives in at most one slot
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        !(pkt_i.active && pkt_i.hit && hit_here))
        else $error("address matched in two slots");

    a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ins_here && !clr) |=> valid_reg)
        else $error("inserted slot not valid");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clr |=> !valid_reg)
        else $error("slot still valid after clear");

    a_insert_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        ins_here |-> (!valid_reg && !pkt_i.active))
        else $error("insert into occupied slot or during search");

endmodule

[rtl/core/ble_tracker_sighting_table_core.sv]
// ----------------------------------------------------------------------------
// ble_tracker_sighting_table_core: advertiser sighting table
// Classifies each sighting, searches a chain of slot cells for its address,
// updates or inserts the entry and reports one result per beat.
// ----------------------------------------------------------------------------
//  channel   direction  tdata / data                        tuser
//  s_*       in         sighting fields (see port)          command
//  m_*       out        index, count, tracker, kind, alert  status
//  cfg_*     in         alert threshold (16 bits)           -
//
// A sighting enters the inject register as a search packet that steps
// through one cell per cycle, is captured and finishes; a clear command
// goes straight to the finish step. Reset empties the table and drops the
// alert at once; no clearing pass. The result sits in an output register;
// a stalled result holds the finish step but not the previous accept.
// ----------------------------------------------------------------------------
module ble_tracker_sighting_table_core #(
    parameter int TABLE_DEPTH = bts_pkg::TABLE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // Sighting input
    input  logic         s_tvalid,
    output logic         s_tready,
    // [47:0] device_address, [55:48] signal_strength, [87:56] time_ms,
    // [92:88] mfg_length, [100:93] mfg_byte0, [108:101] mfg_byte1,
    // [116:109] mfg_byte2, [117] tag_service_seen, [119:118] zero
    input  logic [119:0] s_tdata,
    // [0] command
    input  logic         s_tuser,
    // Result output
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] entry_index, [21:6] sighting_count, [22] is_tracker,
    // [24:23] device_kind, [25] alert, [31:26] zero
    output logic [31:0]  m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,
    // Threshold write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    import bts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] threshold_reg;
    logic               alert_reg, alert_next;
    logic               clear_cmd_reg, clear_cmd_next;
    pkt_t               inject_reg, inject_next;
    pkt_t               res_reg, res_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [31:0]        m_tdata_reg, m_tdata_next;
    logic [1:0]         m_tuser_reg, m_tuser_next;

    pkt_t               chain [0:TABLE_DEPTH];
    ins_t               ins;
    logic               clr;
    logic               in_accept;
    logic               finish;
    logic [KIND_W-1:0]  in_kind;
    logic [STAT_W-1:0]  r_status;
    logic [IDX_W-1:0]   r_idx;
    logic [COUNT_W-1:0] r_count;
    logic               r_tracker;
    logic [KIND_W-1:0]  r_kind;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign finish    = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    assign in_kind = classify(s_tdata[92:88], s_tdata[100:93], s_tdata[108:101],
                              s_tdata[116:109], s_tdata[117]);

    // Cell chain
    assign chain[0] = inject_reg;
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++)
    begin : g_cell
        bts_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .pkt_i (chain[gi]),
            .ins   (ins),
            .clr   (clr),
            .pkt_o (chain[gi+1])
        );
    end

    // Outcome of the finished step
    always_comb
    begin
        r_idx     = '0;
        r_count   = '0;
        r_tracker = 1'b0;
        r_kind    = res_reg.kind;
        if (clear_cmd_reg)
        begin
            r_status = STAT_CLEARED;
            r_kind   = KIND_GENERIC;
        end
        else if (res_reg.hit)
        begin
            r_status  = STAT_UPDATED;
            r_idx     = res_reg.hit_idx;
            r_count   = res_reg.hit_count;
            r_tracker = res_reg.hit_tracker;
            r_kind    = res_reg.hit_kind;
        end
        else if (res_reg.free_seen)
        begin
            r_status  = STAT_INSERTED;
            r_idx     = res_reg.free_idx;
            r_count   = COUNT_W'(1);
            r_tracker = (res_reg.kind != KIND_GENERIC);
        end
        else
        begin
            r_status = STAT_DROPPED;
        end
    end

    // Broadcast writes to the cells
    always_comb
    begin
        clr          = finish && clear_cmd_reg;
        ins.en       = finish && !clear_cmd_reg && !res_reg.hit && res_reg.free_seen;
        ins.idx      = res_reg.free_idx;
        ins.addr     = res_reg.addr;
        ins.strength = res_reg.strength;
        ins.time_ms  = res_reg.time_ms;
        ins.tracker  = (res_reg.kind != KIND_GENERIC);
        ins.kind     = res_reg.kind;
    end

    // Sequencer, alert and output register
    always_comb
    begin
        state_next     = state_reg;
        clear_cmd_next = clear_cmd_reg;
        inject_next    = inject_reg;
        res_next       = res_reg;
        alert_next     = alert_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        inject_next.active = 1'b0;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    clear_cmd_next = s_tuser;
                    if (s_tuser)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        inject_next          = '0;
                        inject_next.active   = 1'b1;
                        inject_next.addr     = s_tdata[47:0];
                        inject_next.strength = s_tdata[55:48];
                        inject_next.time_ms  = s_tdata[87:56];
                        inject_next.kind     = in_kind;
                        state_next           = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (chain[TABLE_DEPTH].active)
                begin
                    res_next   = chain[TABLE_DEPTH];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    if (clear_cmd_reg)
                        alert_next = 1'b0;
                    else if (res_reg.hit && res_reg.hit_tracker &&
                             res_reg.hit_count >= threshold_reg)
                        alert_next = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = r_status;
                    m_tdata_next  = {6'd0, alert_next, r_kind, r_tracker, r_count, r_idx[5:0]};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            threshold_reg <= THRESHOLD_RESET;
            alert_reg     <= 1'b0;
            clear_cmd_reg <= 1'b0;
            inject_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alert_reg     <= alert_next;
            clear_cmd_reg <= clear_cmd_next;
            inject_reg    <= inject_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
                threshold_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A search packet only travels while searching
    a_pkt_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        chain[TABLE_DEPTH].active |-> (state_reg == ST_SEARCH))
        else $error("search packet outside search state");

    // Clear result always reports a dropped alert
    a_clear_drops_alert: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && clear_cmd_reg) |=> (!alert_reg && m_tvalid_reg))
        else $error("alert survived clear");

    // A stalled result beat holds still
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |=>
            (m_tvalid_reg && $stable(m_tdata_reg) && $stable(m_tuser_reg)))
        else $error("result beat changed while stalled");

endmodule

[tb/tb_ble_tracker_sighting_table_core.sv]
// ----------------------------------------------------------------------------
// tb_ble_tracker_sighting_table_core: self-checking bench for the sighting table
// Drives sighting and clear beats into the slave stream and mirrors the table
// in a scoreboard class that predicts every result beat. Result beats are
// checked field by field in order. The run steps through several tracker
// thresholds (reset value, one, the maximum and others), with random idling on
// both streams, one long receiver hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb_ble_tracker_sighting_table_core;
    import bts_pkg::*;

    // One slave-side beat, unpacked
    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] addr;
        logic [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0] time_ms;
        logic [LEN_W-1:0]  mfg_len;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic              tag_svc;
    } sighting_t;

    // One master-side beat, unpacked
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [5:0]         index;
        logic [COUNT_W-1:0] count;
        logic               tracker;
        logic [KIND_W-1:0]  kind;
        logic               alert;
    } table_result_t;

    // Shadow copy of the sighting table plus the queue of predicted results
    class sighting_table_model;
        localparam int SLOTS = TABLE_DEPTH_DEF;

        bit                 slot_valid   [SLOTS];
        logic [ADDR_W-1:0]  slot_addr    [SLOTS];
        logic [RSSI_W-1:0]  slot_rssi    [SLOTS];
        logic [COUNT_W-1:0] slot_count   [SLOTS];
        logic [TIME_W-1:0]  slot_first   [SLOTS];
        logic [TIME_W-1:0]  slot_last    [SLOTS];
        bit                 slot_tracker [SLOTS];
        logic [KIND_W-1:0]  slot_kind    [SLOTS];
        int unsigned        used;
        bit                 alert;
        logic [COUNT_W-1:0] threshold;
        table_result_t      expected_results [$];
        int                 errors;

        function new();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            used      = 0;
            alert     = 1'b0;
            threshold = THRESHOLD_RESET;
            errors    = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // First matching signature wins; length must cover the compared bytes
        function logic [KIND_W-1:0] classify_adv(sighting_t s);
            if (s.mfg_len >= 5'd3 && s.b0 == MFG_A_B0 && s.b1 == MFG_A_B1 && s.b2 == MFG_A_B2)
                return KIND_MFG_A;
            if (s.mfg_len >= 5'd2 && s.b0 == MFG_B_B0 && s.b1 == MFG_B_B1)
                return KIND_MFG_B;
            if (s.tag_svc)
                return KIND_SERVICE;
            return KIND_GENERIC;
        endfunction

        // Apply one accepted beat to the shadow table and queue its result
        function void note_sighting(sighting_t s);
            table_result_t     r;
            logic [KIND_W-1:0] k;
            int                hit;
            int                free_slot;
            r = '0;
            if (s.command)
            begin
                foreach (slot_valid[i]) slot_valid[i] = 1'b0;
                used   = 0;
                alert  = 1'b0;
                r.status = STAT_CLEARED;
            end
            else
            begin
                k   = classify_adv(s);
                hit = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_valid[i] && slot_addr[i] == s.addr)
                        hit = i;
                if (hit >= 0)
                begin
                    // known address: refresh, count up, tracker flag is sticky
                    slot_rssi[hit] = s.rssi;
                    if (slot_count[hit] != COUNT_MAX)
                        slot_count[hit] = slot_count[hit] + 1'b1;
                    slot_last[hit] = s.time_ms;
                    if (k != KIND_GENERIC)
                    begin
                        slot_tracker[hit] = 1'b1;
                        slot_kind[hit]    = k;
                    end
                    if (slot_tracker[hit] && slot_count[hit] >= threshold)
                        alert = 1'b1;
                    r.status  = STAT_UPDATED;
                    r.index   = 6'(hit);
                    r.count   = slot_count[hit];
                    r.tracker = slot_tracker[hit];
                    r.kind    = slot_kind[hit];
                end
                else
                begin
                    free_slot = -1;
                    if (used < SLOTS)
                        for (int i = 0; i < SLOTS; i++)
                            if (free_slot < 0 && !slot_valid[i])
                                free_slot = i;
                    if (free_slot >= 0)
                    begin
                        // lowest free slot, count starts at one, no alert test
                        slot_valid[free_slot]   = 1'b1;
                        slot_addr[free_slot]    = s.addr;
                        slot_rssi[free_slot]    = s.rssi;
                        slot_count[free_slot]   = 16'd1;
                        slot_first[free_slot]   = s.time_ms;
                        slot_last[free_slot]    = s.time_ms;
                        slot_tracker[free_slot] = (k != KIND_GENERIC);
                        slot_kind[free_slot]    = k;
                        used++;
                        r.status  = STAT_INSERTED;
                        r.index   = 6'(free_slot);
                        r.count   = 16'd1;
                        r.tracker = (k != KIND_GENERIC);
                        r.kind    = k;
                    end
                    else
                    begin
                        // table full: only the sighting's own kind is reported
                        r.status = STAT_DROPPED;
                        r.kind   = k;
                    end
                end
            end
            r.alert = alert;
            expected_results = {expected_results, r};
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        // Compare one result beat against the oldest prediction
        function void check_result(logic [1:0] status, logic [31:0] data);
            table_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d data %h", status, data);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            compare_field("status",         e.status,  status);
            compare_field("entry_index",    e.index,   data[5:0]);
            compare_field("sighting_count", e.count,   data[21:6]);
            compare_field("is_tracker",     e.tracker, data[22]);
            compare_field("device_kind",    e.kind,    data[24:23]);
            compare_field("alert",          e.alert,   data[25]);
            compare_field("tdata_pad",      0,         data[31:26]);
        endfunction
    endclass

    localparam int ITEMS       = 1300;
    localparam int PHASES      = 6;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data  = '0;

    sighting_table_model table_model = new();

    bit steady        = 1'b0;   // no idling on either side while set
    int hold_requests = 0;      // bumped to ask the receiver for a long hold-off
    int offered       = 0;
    int cycle_count   = 0;

    ble_tracker_sighting_table_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, steady stretch, long hold-off on request
    initial
    begin
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 22);
        end
    end

    // Result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                table_model.check_result(m_tuser, m_tdata);
        end
    end

    function automatic sighting_t build_sighting(
        input logic [47:0] addr, input logic [7:0] rssi, input logic [31:0] t,
        input logic [4:0] len, input logic [7:0] b0, input logic [7:0] b1,
        input logic [7:0] b2, input logic svc
    );
        sighting_t s;
        s.command = 1'b0;
        s.addr    = addr;
        s.rssi    = rssi;
        s.time_ms = t;
        s.mfg_len = len;
        s.b0      = b0;
        s.b1      = b1;
        s.b2      = b2;
        s.tag_svc = svc;
        return s;
    endfunction

    function automatic logic [47:0] random_address();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Random content, biased toward the tracker signatures and near misses
    function automatic sighting_t random_sighting(input logic [47:0] addr);
        sighting_t s;
        int        pick;
        s = build_sighting(addr, 8'($urandom), $urandom, 5'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), ($urandom_range(99) < 30));
        if ($urandom_range(99) < 50)
            s.mfg_len = 5'($urandom_range(0, 4));
        pick = $urandom_range(99);
        if (pick < 35)
            {s.b0, s.b1, s.b2} = {MFG_A_B0, MFG_A_B1, MFG_A_B2};
        else if (pick < 60)
            {s.b0, s.b1} = {MFG_B_B0, MFG_B_B1};
        else if (pick < 75)
        begin
            // one bit off the first signature
            {s.b0, s.b1, s.b2} = {MFG_A_B0, MFG_A_B1, MFG_A_B2};
            {s.b0, s.b1, s.b2} = {s.b0, s.b1, s.b2} ^ (24'd1 << $urandom_range(23));
        end
        return s;
    endfunction

    // Offer one beat on the slave stream and record it once accepted
    task automatic offer_sighting(input sighting_t s);
        if (!steady && $urandom_range(99) < 22)
        begin
            s_tvalid <= 1'b0;
            if ($urandom_range(9) < 7)
                repeat ($urandom_range(1, 4)) @(posedge clk);
            else
                repeat ($urandom_range(5, 90)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.command;
        s_tdata  <= {2'b00, s.tag_svc, s.b2, s.b1, s.b0, s.mfg_len, s.time_ms,
                     s.rssi, s.addr};
        do @(posedge clk); while (!s_tready);
        table_model.note_sighting(s);
        offered++;
    endtask

    task automatic offer_clear();
        sighting_t s;
        s = random_sighting(random_address());
        s.command = 1'b1;
        offer_sighting(s);
    endtask

    // Sender pause until every predicted result has been seen
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (table_model.pending() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        logic [47:0] a0;
        logic [47:0] a1;
        logic [47:0] a2;
        logic [47:0] a3;
        logic [15:0] phase_threshold [PHASES];
        logic [47:0] pool [$];
        int          pool_size;
        int          burst;
        int          target;

        a0 = 48'h0;
        a1 = '1;
        a2 = 48'h0000_1234_5678;
        a3 = 48'hA5A5_5A5A_0F0F;
        phase_threshold[0] = THRESHOLD_RESET;
        phase_threshold[1] = 16'd1;
        phase_threshold[2] = 16'hFFFF;
        phase_threshold[3] = 16'd2;
        phase_threshold[4] = 16'($urandom_range(1, 65535));
        phase_threshold[5] = 16'd3;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, each kind, signature priority, alert, clear
        offer_sighting(build_sighting(a0, 8'h80, 32'h0, 5'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        offer_sighting(build_sighting(a1, 8'h7F, '1, 5'd31, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        offer_sighting(build_sighting(a0, 8'hFF, 32'd1, 5'd3, MFG_A_B0, MFG_A_B1, MFG_A_B2,
                                      1'b0));
        // too short for the first signature, falls through to the service flag
        offer_sighting(build_sighting(a2, 8'h00, 32'd100, 5'd2, MFG_A_B0, MFG_A_B1, MFG_A_B2,
                                      1'b1));
        offer_sighting(build_sighting(a3, 8'h05, 32'd200, 5'd2, MFG_B_B0, MFG_B_B1, 8'hAB,
                                      1'b0));
        // generic sighting on a tracker entry keeps its kind
        offer_sighting(build_sighting(a3, 8'h05, 32'd201, 5'd1, MFG_B_B0, MFG_B_B1, 8'h00,
                                      1'b0));
        offer_sighting(build_sighting(a2, 8'h00, 32'd300, 5'd31, MFG_A_B0, MFG_A_B1, 8'h13,
                                      1'b0));
        // first signature wins over the service flag, then the kind is replaced
        offer_sighting(build_sighting(a1, 8'h01, 32'd400, 5'd3, MFG_A_B0, MFG_A_B1, MFG_A_B2,
                                      1'b1));
        offer_sighting(build_sighting(a1, 8'h02, 32'd401, 5'd4, MFG_B_B0, MFG_B_B1, 8'h12,
                                      1'b1));
        // walk a0 past the reset threshold
        repeat (4)
            offer_sighting(build_sighting(a0, 8'hC4, 32'd500, 5'd0, 8'h00, 8'h00, 8'h00,
                                          1'b0));
        offer_clear();
        offer_sighting(build_sighting(a2, 8'hAA, 32'd600, 5'd0, 8'h55, 8'hAA, 8'h55, 1'b0));
        repeat (4)
            offer_sighting(build_sighting(a2, 8'h55, 32'd601, 5'd0, 8'hAA, 8'h55, 8'hAA,
                                          1'b1));
        offer_clear();

        // Random phases, one threshold each
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_for_results();
                cfg_valid <= 1'b1;
                cfg_data  <= phase_threshold[phase];
                do @(posedge clk); while (!cfg_ready);
                cfg_valid <= 1'b0;
                table_model.threshold = phase_threshold[phase];
            end
            steady = (phase == 2);
            if (phase == 3)
                hold_requests++;
            target = (phase + 1) * ITEMS / PHASES;
            while (offered < target)
            begin
                // one episode: a pool of addresses seen again and again
                pool_size = $urandom_range(2, 80);
                pool.delete();
                repeat (pool_size) pool = {pool, random_address()};
                burst = $urandom_range(20, 60);
                repeat (burst)
                begin
                    if ($urandom_range(99) == 0)
                        offer_clear();
                    else if ($urandom_range(99) < 15)
                        offer_sighting(random_sighting(random_address()));
                    else
                        offer_sighting(random_sighting(pool[$urandom_range(pool.size() - 1)]));
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (table_model.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/core/bts_pkg.sv
rtl/core/bts_cell.sv
rtl/core/ble_tracker_sighting_table_core.sv
tb/tb_ble_tracker_sighting_table_core.sv
